// File: src/cfs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the cylindrical feedrate split block
// no dependencies

package cfs_pkg;

    localparam int DATA_W     = 32;              // signed q16.16 input width
    localparam int FRAC_W     = 16;
    localparam int FEED_W     = DATA_W - 1;      // unsigned feed and speed width
    localparam int MAG_W      = DATA_W;          // magnitude of a signed input
    localparam int PROD_W     = 2 * MAG_W;
    localparam int RT_W       = PROD_W - FRAC_W; // arc component width
    localparam int RT_MSB_W   = 6;               // bit index into the arc component
    localparam int K_W        = 5;               // normalize shift
    localparam int NORM_W     = DATA_W - 1;      // normalized magnitude width
    localparam int SUM_W      = 2 * DATA_W;      // sum of squares
    localparam int ROOT_W     = DATA_W;
    localparam int SREM_W     = ROOT_W + 1;
    localparam int DEN_W      = ROOT_W + RT_W - NORM_W;
    localparam int NUM_W      = FEED_W + MAG_W - 1;
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = NUM_W;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;

    localparam logic [FEED_W-1:0] SAT_MAX = '1;

    localparam logic [1:0] AXIS_R     = 2'd0;
    localparam logic [1:0] AXIS_THETA = 2'd1;
    localparam logic [1:0] AXIS_Z     = 2'd2;

    typedef struct packed {
        logic [FEED_W-1:0] feed;
        logic [MAG_W-1:0]  dr;
        logic [MAG_W-1:0]  dt;
        logic [MAG_W-1:0]  dz;
        logic [MAG_W-1:0]  ravg;
        logic              feed_only;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_NUM,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } t_state;

endpackage

// File: src/cylindrical_feedrate_split.sv
`timescale 1ns / 1ps
// top level of the cylindrical feedrate split: front end, queue, engine
// depends on cfs_pkg, cfs_front, cfs_queue, cfs_engine
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  input   | i_in_valid / o_in_ready   | feed_rate, delta_r/theta/z, r_start, r_end
//  output  | o_out_valid / i_out_ready | r_speed, rot_speed, z_speed, overflow
//
// a move with radial or rotary motion holds the engine through accept, multiply,
// normalize, 3 squares, 32 root steps, 3 x (62 division steps + 2), output
// a move with neither goes from accept to output; a zero divisor skips the divisions
// the two-entry queue accepts items, until full, while the engine is busy or the
// output register holds an untaken result; sync reset empties queue and output

module cylindrical_feedrate_split
    import cfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FEED_W-1:0] i_feed_rate,
    input  logic [DATA_W-1:0] i_delta_r,
    input  logic [DATA_W-1:0] i_delta_theta,
    input  logic [DATA_W-1:0] i_delta_z,
    input  logic [DATA_W-1:0] i_r_start,
    input  logic [DATA_W-1:0] i_r_end,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [FEED_W-1:0] o_r_speed,
    output logic [FEED_W-1:0] o_rot_speed,
    output logic [FEED_W-1:0] o_z_speed,
    output logic              o_overflow
);

    t_job w_front_job;
    t_job w_head_job;
    logic w_head_valid;
    logic w_head_ready;

    cfs_front u_front (
        .i_feed_rate   (i_feed_rate),
        .i_delta_r     (i_delta_r),
        .i_delta_theta (i_delta_theta),
        .i_delta_z     (i_delta_z),
        .i_r_start     (i_r_start),
        .i_r_end       (i_r_end),
        .o_job         (w_front_job)
    );

    cfs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_in_valid),
        .o_wr_ready (o_in_ready),
        .i_wr_data  (w_front_job),
        .o_rd_valid (w_head_valid),
        .i_rd_ready (w_head_ready),
        .o_rd_data  (w_head_job)
    );

    cfs_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_head_valid),
        .o_job_ready   (w_head_ready),
        .i_job         (w_head_job),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_r_speed     (o_r_speed),
        .o_rot_speed   (o_rot_speed),
        .o_z_speed     (o_z_speed),
        .o_overflow    (o_overflow)
    );

endmodule

// File: src/cfs_front.sv
`timescale 1ns / 1ps
// front end: magnitudes, mean radius and classification of one move
// depends on cfs_pkg

module cfs_front
    import cfs_pkg::*;
(
    input  logic [FEED_W-1:0] i_feed_rate,
    input  logic [DATA_W-1:0] i_delta_r,
    input  logic [DATA_W-1:0] i_delta_theta,
    input  logic [DATA_W-1:0] i_delta_z,
    input  logic [DATA_W-1:0] i_r_start,
    input  logic [DATA_W-1:0] i_r_end,
    output t_job              o_job
);

    logic [DATA_W:0] w_rsum;
    logic [DATA_W:0] w_rabs;

    function automatic logic [MAG_W-1:0] mag(input logic [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign w_rsum = {i_r_start[DATA_W-1], i_r_start} + {i_r_end[DATA_W-1], i_r_end};
    assign w_rabs = w_rsum[DATA_W] ? (~w_rsum + 1'b1) : w_rsum;

    always_comb begin
        o_job.feed      = i_feed_rate;
        o_job.dr        = mag(i_delta_r);
        o_job.dt        = mag(i_delta_theta);
        o_job.dz        = mag(i_delta_z);
        o_job.ravg      = w_rabs[DATA_W:1];
        // no radial and no rotary motion: axial axis takes the whole feed
        o_job.feed_only = (i_delta_r == '0) && (i_delta_theta == '0);
    end

endmodule

// File: src/cfs_queue.sv
`timescale 1ns / 1ps
// two-entry queue between front end and arithmetic engine
// depends on cfs_pkg

module cfs_queue
    import cfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_job i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_job o_rd_data
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_wr_ready = (r_count != (QPTR_W + 1)'(QDEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: src/cfs_engine.sv
`timescale 1ns / 1ps
// back end: arc multiply, normalize, sum of squares, bitwise square root,
// three restoring divisions and the output register; depends on cfs_pkg

module cfs_engine
    import cfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  t_job              i_job,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [FEED_W-1:0] o_r_speed,
    output logic [FEED_W-1:0] o_rot_speed,
    output logic [FEED_W-1:0] o_z_speed,
    output logic              o_overflow
);

    t_state             r_state, n_state;
    t_job               r_job, n_job;
    logic [RT_W-1:0]    r_rt, n_rt;
    logic [K_W-1:0]     r_k, n_k;
    logic [1:0]         r_axis, n_axis;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SREM_W-1:0]  r_srem, n_srem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [NUM_W-1:0]   r_quo, n_quo;
    logic [DEN_W-1:0]   r_drem, n_drem;
    logic [FEED_W-1:0]  r_rs, n_rs, r_ts, n_ts, r_zs, n_zs;
    logic               r_ovf, n_ovf;
    logic               r_out_valid, n_out_valid;
    logic [FEED_W-1:0]  r_out_rs, n_out_rs, r_out_ts, n_out_ts, r_out_zs, n_out_zs;
    logic               r_out_ovf, n_out_ovf;

    logic [PROD_W-1:0]   w_arc;
    logic [RT_W-1:0]     w_max;
    logic [RT_MSB_W-1:0] w_msb;
    logic [RT_W-1:0]     w_sel;
    logic [NORM_W-1:0]   w_norm;
    logic [SREM_W+1:0]   w_srem_n;
    logic [SREM_W+1:0]   w_trial;
    logic [MAG_W-1:0]    w_axis_mag;
    logic [DEN_W:0]      w_drem_n;
    logic                w_qbit;
    logic [FEED_W-1:0]   w_clamped;
    logic                w_sat;

    assign o_job_ready   = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_r_speed     = r_out_rs;
    assign o_rot_speed   = r_out_ts;
    assign o_z_speed     = r_out_zs;
    assign o_overflow    = r_out_ovf;

    always_comb begin
        w_arc = r_job.ravg * r_job.dt;

        // largest of the three magnitudes and its leading bit
        w_max = RT_W'(r_job.dr);
        if (r_rt > w_max) begin
            w_max = r_rt;
        end
        if (RT_W'(r_job.dz) > w_max) begin
            w_max = RT_W'(r_job.dz);
        end
        w_msb = '0;
        for (int i = 0; i < RT_W; i++) begin
            if (w_max[i]) begin
                w_msb = RT_MSB_W'(i);
            end
        end

        case (r_axis)
            AXIS_R:     w_sel = RT_W'(r_job.dr);
            AXIS_THETA: w_sel = r_rt;
            default:    w_sel = RT_W'(r_job.dz);
        endcase
        w_norm = NORM_W'(w_sel >> r_k);

        w_srem_n = {r_srem, r_sum[SUM_W-1 -: 2]};
        w_trial  = {1'b0, r_root, 2'b01};

        case (r_axis)
            AXIS_R:     w_axis_mag = r_job.dr;
            AXIS_THETA: w_axis_mag = r_job.dt;
            default:    w_axis_mag = r_job.dz;
        endcase

        w_drem_n = {r_drem, r_num[NUM_W-1]};
        w_qbit   = (w_drem_n >= {1'b0, r_den});

        w_sat     = |r_quo[NUM_W-1:FEED_W];
        w_clamped = w_sat ? SAT_MAX : r_quo[FEED_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_rt        = r_rt;
        n_k         = r_k;
        n_axis      = r_axis;
        n_sum       = r_sum;
        n_srem      = r_srem;
        n_root      = r_root;
        n_cnt       = r_cnt;
        n_den       = r_den;
        n_num       = r_num;
        n_quo       = r_quo;
        n_drem      = r_drem;
        n_rs        = r_rs;
        n_ts        = r_ts;
        n_zs        = r_zs;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_rs    = r_out_rs;
        n_out_ts    = r_out_ts;
        n_out_zs    = r_out_zs;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_job = i_job;
                    n_rs  = '0;
                    n_ts  = '0;
                    n_zs  = i_job.feed;
                    n_ovf = 1'b0;
                    n_state = i_job.feed_only ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL: begin
                n_rt    = w_arc[PROD_W-1:FRAC_W];
                n_state = ST_NORM;
            end
            ST_NORM: begin
                // smallest shift that leaves every magnitude below 2^31
                n_k     = (w_msb >= RT_MSB_W'(NORM_W)) ?
                          K_W'(w_msb - RT_MSB_W'(NORM_W - 1)) : '0;
                n_sum   = '0;
                n_axis  = AXIS_R;
                n_state = ST_SQ;
            end
            ST_SQ: begin
                n_sum = r_sum + SUM_W'(w_norm * w_norm);
                if (r_axis == AXIS_Z) begin
                    n_srem  = '0;
                    n_root  = '0;
                    n_cnt   = '0;
                    n_state = ST_SQRT;
                end else begin
                    n_axis = r_axis + 1'b1;
                end
            end
            ST_SQRT: begin
                // two bits of the radicand per step
                n_sum = r_sum << 2;
                if (w_srem_n >= w_trial) begin
                    n_srem = SREM_W'(w_srem_n - w_trial);
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_srem = SREM_W'(w_srem_n);
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_axis  = AXIS_R;
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                if (r_root == '0) begin
                    // zero divisor
                    n_rs    = '0;
                    n_ts    = SAT_MAX;
                    n_zs    = '0;
                    n_ovf   = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_den   = DEN_W'(r_root) << r_k;
                    n_num   = NUM_W'(r_job.feed * w_axis_mag);
                    n_quo   = '0;
                    n_drem  = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_num  = r_num << 1;
                n_quo  = {r_quo[NUM_W-2:0], w_qbit};
                n_drem = w_qbit ? DEN_W'(w_drem_n - {1'b0, r_den}) : DEN_W'(w_drem_n);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                n_ovf = r_ovf || w_sat;
                case (r_axis)
                    AXIS_R:     n_rs = w_clamped;
                    AXIS_THETA: n_ts = w_clamped;
                    default:    n_zs = w_clamped;
                endcase
                if (r_axis == AXIS_Z) begin
                    n_state = ST_OUT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = ST_NUM;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_rs    = r_rs;
                    n_out_ts    = r_ts;
                    n_out_zs    = r_zs;
                    n_out_ovf   = r_ovf;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_rt      <= n_rt;
        r_k       <= n_k;
        r_axis    <= n_axis;
        r_sum     <= n_sum;
        r_srem    <= n_srem;
        r_root    <= n_root;
        r_cnt     <= n_cnt;
        r_den     <= n_den;
        r_num     <= n_num;
        r_quo     <= n_quo;
        r_drem    <= n_drem;
        r_rs      <= n_rs;
        r_ts      <= n_ts;
        r_zs      <= n_zs;
        r_ovf     <= n_ovf;
        r_out_rs  <= n_out_rs;
        r_out_ts  <= n_out_ts;
        r_out_zs  <= n_out_zs;
        r_out_ovf <= n_out_ovf;
    end

endmodule

// File: tb/cfs_checker.sv
`timescale 1ns / 1ps
// checker for the cylindrical feedrate split: watches both channels,
// predicts axis speeds per accepted move and compares; depends on cfs_pkg

module cfs_checker
    import cfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [FEED_W-1:0] i_feed_rate,
    input  logic [DATA_W-1:0] i_delta_r,
    input  logic [DATA_W-1:0] i_delta_theta,
    input  logic [DATA_W-1:0] i_delta_z,
    input  logic [DATA_W-1:0] i_r_start,
    input  logic [DATA_W-1:0] i_r_end,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [FEED_W-1:0] i_r_speed,
    input  logic [FEED_W-1:0] i_rot_speed,
    input  logic [FEED_W-1:0] i_z_speed,
    input  logic              i_overflow,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_moves_seen,
    output int                o_sat_seen
);

    typedef struct packed {
        logic [FEED_W-1:0] r_spd;
        logic [FEED_W-1:0] t_spd;
        logic [FEED_W-1:0] z_spd;
        logic              ovf;
    } t_speeds;

    t_speeds speeds_q[$];

    function automatic logic [63:0] mag32(logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? 64'(33'h1_0000_0000 - {1'b0, v}) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] clamp(logic [127:0] v, inout logic ovf);
        if (v > 128'(SAT_MAX)) begin
            ovf = 1'b1;
            return 64'(SAT_MAX);
        end
        return v[63:0];
    endfunction

    function automatic t_speeds split_feed(logic [FEED_W-1:0] feed,
            logic [DATA_W-1:0] r, logic [DATA_W-1:0] t, logic [DATA_W-1:0] z,
            logic [DATA_W-1:0] rs, logic [DATA_W-1:0] re);
        t_speeds o;
        logic [63:0] dr, dt, dz, ravg, rt, m, a, b, c, d;
        logic [127:0] den;
        logic signed [33:0] sum;
        logic ovf;
        int k;
        dr = mag32(r);
        dt = mag32(t);
        dz = mag32(z);
        sum = 34'(signed'(rs)) + 34'(signed'(re));
        ravg = 64'(sum < 0 ? -sum : sum) >> 1;
        o = '0;
        ovf = 1'b0;
        if (dr == 0 && dt == 0) begin
            o.z_spd = feed;
        end else begin
            rt = (ravg * dt) >> FRAC_W;
            m = dr;
            if (rt > m) m = rt;
            if (dz > m) m = dz;
            k = 0;
            while ((m >> k) > 64'h7FFF_FFFF) k++;
            a = dr >> k;
            b = rt >> k;
            c = dz >> k;
            d = root64(a * a + b * b + c * c);
            if (d == 0) begin
                o.t_spd = SAT_MAX;
                ovf = 1'b1;
            end else begin
                den = 128'(d) << k;
                o.r_spd = FEED_W'(clamp((128'(feed) * dr) / den, ovf));
                o.t_spd = FEED_W'(clamp((128'(feed) * dt) / den, ovf));
                o.z_spd = FEED_W'(clamp((128'(feed) * dz) / den, ovf));
            end
        end
        o.ovf = ovf;
        return o;
    endfunction

    assign o_pending = speeds_q.size();

    always @(posedge i_clk) begin
        t_speeds e;
        if (!i_rst_n) begin
            speeds_q.delete();
            o_fail_count <= 0;
            o_moves_seen <= 0;
            o_sat_seen <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                speeds_q.push_back(split_feed(i_feed_rate, i_delta_r, i_delta_theta,
                                              i_delta_z, i_r_start, i_r_end));
                o_moves_seen <= o_moves_seen + 1;
            end
            if (i_out_valid && i_out_ready) begin
                if (speeds_q.size() == 0) begin
                    $error("speed item with no move pending");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = speeds_q.pop_front();
                    if (e.ovf) o_sat_seen <= o_sat_seen + 1;
                    if (e != {i_r_speed, i_rot_speed, i_z_speed, i_overflow})
                        o_fail_count <= o_fail_count + 1;
                    if (e.r_spd != i_r_speed)
                        $error("r_speed expected %0d got %0d", e.r_spd, i_r_speed);
                    if (e.t_spd != i_rot_speed)
                        $error("rot_speed expected %0d got %0d", e.t_spd, i_rot_speed);
                    if (e.z_spd != i_z_speed)
                        $error("z_speed expected %0d got %0d", e.z_spd, i_z_speed);
                    if (e.ovf != i_overflow)
                        $error("overflow expected %0d got %0d", e.ovf, i_overflow);
                end
            end
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// top of the cylindrical feedrate split testbench: clock, reset, move stimulus,
// output stalls and verdict; depends on cfs_pkg, cfs_checker and the block

module tb_top
    import cfs_pkg::*;
;

    localparam int N_RANDOM = 1000;
    localparam int WATCHDOG = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [FEED_W-1:0] feed_rate = '0;
    logic [DATA_W-1:0] delta_r = '0, delta_theta = '0, delta_z = '0;
    logic [DATA_W-1:0] r_start = '0, r_end = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [FEED_W-1:0] r_speed, rot_speed, z_speed;
    logic              overflow;
    int                fail_count, pending, moves_seen, sat_seen;
    bit                no_idle = 1'b0;
    bit                hold_off = 1'b0;
    int                quiet_cycles = 0;
    int                stall_left = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cylindrical_feedrate_split DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_feed_rate(feed_rate), .i_delta_r(delta_r), .i_delta_theta(delta_theta),
        .i_delta_z(delta_z), .i_r_start(r_start), .i_r_end(r_end),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_r_speed(r_speed), .o_rot_speed(rot_speed), .o_z_speed(z_speed),
        .o_overflow(overflow)
    );

    cfs_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_feed_rate(feed_rate), .i_delta_r(delta_r), .i_delta_theta(delta_theta),
        .i_delta_z(delta_z), .i_r_start(r_start), .i_r_end(r_end),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_r_speed(r_speed), .i_rot_speed(rot_speed), .i_z_speed(z_speed),
        .i_overflow(overflow),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_moves_seen(moves_seen), .o_sat_seen(sat_seen)
    );

    // random-width value so small, medium and full-scale magnitudes all show up
    function automatic logic [DATA_W-1:0] rand_word();
        logic [DATA_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 4))
            0: v = v >> $urandom_range(1, 31);
            1: v = {{16{v[31]}}, v[15:0]};
            2: v = 0;
            default: ;
        endcase
        return v;
    endfunction

    // sends one move, with a random gap before it unless idling is off
    // valid stays high into the next move when there is no gap
    task automatic send_move(logic [FEED_W-1:0] f, logic [DATA_W-1:0] r,
                             logic [DATA_W-1:0] t, logic [DATA_W-1:0] z,
                             logic [DATA_W-1:0] rs, logic [DATA_W-1:0] re);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        feed_rate <= f;
        delta_r <= r;
        delta_theta <= t;
        delta_z <= z;
        r_start <= rs;
        r_end <= re;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n || hold_off) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else if (no_idle) begin
            out_ready <= 1'b1;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            out_ready <= 1'b1;
        end else if (!out_ready) begin
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(1, 8);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d moves pending", pending);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: feed-only, zero divisor, saturation, extremes
        send_move(31'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
        send_move(31'd0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_move(31'h0001_0000, 0, 32'h0001_0000, 0, 0, 0);
        send_move(31'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'h0000_8000, 32'hFFFF_8000);
        send_move(31'h7FFF_FFFF, 1, 0, 0, 0, 0);
        send_move(31'h7FFF_FFFF, 0, 32'h0000_0001, 0, 32'h0000_0001, 0);
        send_move(31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);
        send_move(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_move(31'h0001_0000, 32'h0003_0000, 0, 32'h0004_0000, 0, 0);
        send_move(31'h0001_0000, 32'hFFFD_0000, 32'h0001_0000, 32'hFFFC_0000,
                  32'h0002_0000, 32'h0004_0000);
        send_move(31'h0010_0000, 0, 32'hFFFF_0000, 32'h0001_0000,
                  32'hFFFE_0000, 32'hFFFC_0000);
        send_move(31'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000);
        send_move(31'd1, 32'hFFFF_FFFF, 0, 0, 0, 0);

        // long output hold-off while moves keep coming, to fill the queue
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (6) send_move(FEED_W'($urandom()), rand_word(), rand_word(),
                                 rand_word(), rand_word(), rand_word());
        join

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 100) no_idle = 1'b1;
            send_move($urandom_range(0, 3) == 0 ? FEED_W'($urandom()) :
                      FEED_W'($urandom_range(0, 32'h0100_0000)),
                      rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("checked %0d moves, %0d of them saturating or zero-divisor",
                 moves_seen, sat_seen);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
